/* hdl/scfk_pkg.sv */
package scfk_pkg;

    typedef enum logic [2:0] {
        OP_ROT     = 3'd0,
        OP_TAIL    = 3'd1,
        OP_ANGLE   = 3'd2,
        OP_MAP     = 3'd3,
        OP_COMPUTE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        CFG_LENGTH = 2'd0,
        CFG_COUNT  = 2'd1,
        CFG_JVC    = 2'd2
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMIT,
        ST_TAIL,
        ST_RDP,
        ST_CP,
        ST_WCP,
        ST_RDY,
        ST_CY,
        ST_WCY,
        ST_MAC
    } t_state;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_RED,
        CS_WRAP,
        CS_FOLD,
        CS_ITER,
        CS_FIN
    } t_cstate;

    localparam int DEF_MAX_LINKS        = 16;
    localparam int DEF_MAX_JOINT_VALUES = 32;
    localparam int DEF_CORDIC_STEPS     = 24;

    localparam int ZW = 35;
    typedef logic signed [ZW-1:0] t_cw;
    typedef logic signed [31:0]   t_word;

    localparam t_cw TWO_PI_Q30  = 35'sd6746518852;
    localparam t_cw PI_Q30      = 35'sd3373259426;
    localparam t_cw HALF_PI_Q30 = 35'sd1686629713;
    localparam t_cw CORDIC_GAIN = 35'sd652032874;
    localparam t_cw ONE_Q30     = 35'sd1073741824;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000008;
            5'd28: v = 30'h00000004;
            5'd29: v = 30'h00000002;
            5'd30: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* hdl/serial_chain_forward_kinematics_core.sv */
// Forward kinematics of a chain of equal links.
// Input channel s_axis: load items store the root rotation (one column per item),
// the tail of the first link, joint angles and the per-joint pitch/yaw slot map;
// loads are taken back to back while the block is idle. A compute item makes the block busy (s_axis_tready
// low) until its last endpoint has been handed to the output register.
// Output channel m_axis: one item per endpoint, index 0..link_count, tlast on the
// final one; an empty chain (link count or length zero) gives a single item with
// tuser set, zero payload and tlast.
// Point 0 is found by three multiply-accumulate jobs before it is emitted, point 1 is
// the stored tail; every further link needs two sequential CORDIC runs (pitch, then
// yaw) and fifteen multiply-accumulate jobs that share the single 32x32 multiplier.
// Joint angles sit in a synchronous memory read once per CORDIC run.
// A stalled receiver holds the item in the output register; the chain walk then
// waits in its emit step. Reset (synchronous, active low) clears the control state,
// the configuration, the stored matrix and tail and the angle valid bits (unwritten
// angles read as zero) and sets the slot map to none.
module serial_chain_forward_kinematics_core import scfk_pkg::*; #(
    parameter int MAX_LINKS        = DEF_MAX_LINKS,
    parameter int MAX_JOINT_VALUES = DEF_MAX_JOINT_VALUES,
    parameter int CORDIC_STEPS     = DEF_CORDIC_STEPS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // opcode, slot, value_x, value_y, value_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // point_index, point_x, point_y, point_z
    output logic         m_axis_tlast,
    output logic [0:0]   m_axis_tuser,   // empty_res
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_data
);

    localparam int LW   = $clog2(MAX_LINKS + 1);
    localparam int JW   = $clog2(MAX_JOINT_VALUES + 1);
    localparam int AW   = (MAX_JOINT_VALUES > 1) ? $clog2(MAX_JOINT_VALUES) : 1;
    localparam int NMAP = MAX_LINKS - 1;
    localparam int MW   = (NMAP > 1) ? $clog2(NMAP) : 1;
    localparam logic [3:0] JOB_R0   = 4'd6;
    localparam logic [3:0] JOB_P0   = 4'd12;
    localparam logic [3:0] JOB_LAST = 4'd14;

    function automatic t_word sat32(input logic signed [65:0] v);
        t_word r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [6:0] map_value(input t_word v);
        return (v < 0 || v > 63) ? 7'h7F : v[6:0];
    endfunction

    t_state r_state, n_state;

    logic [2:0] in_op;
    logic [4:0] in_slot;
    t_word      in_x, in_y, in_z;
    logic       in_acc, chain_empty, emit_last, out_load, rd_en, cord_start, cord_done;

    logic [30:0]   r_len;
    logic [LW-1:0] r_n;
    logic [JW-1:0] r_jvc;
    t_word         r_rot_ld [9];
    t_word         r_tail [3];
    logic [6:0]    r_pitch [NMAP];
    logic [6:0]    r_yaw [NMAP];
    logic [MAX_JOINT_VALUES-1:0] r_av;
    t_word         r_mem [MAX_JOINT_VALUES];
    t_word         r_mem_q;
    logic          r_ang_ok;

    logic [LW-1:0] r_idx;
    logic [3:0]    r_job;
    logic [1:0]    r_ph;
    logic          r_sub, r_empty;

    t_word r_rw [9];
    t_word r_t0 [3];
    t_word r_t2 [3];
    t_word r_p [3];
    t_word r_sp, r_cp, r_sy, r_cy;
    logic signed [63:0] r_prod;
    logic signed [64:0] r_acc;
    t_word r_res;

    logic          r_ov, r_out_last, r_out_empty;
    logic [4:0]    r_out_idx;
    t_word         r_out_p [3];

    logic [MW-1:0] map_i;
    logic [6:0]    rd_slot;
    logic          rd_ok;
    t_word         cord_ang, cord_sin, cord_cos;
    logic [1:0]    row;
    logic [3:0]    ridx;
    t_word         rval, mul_a, mul_b, res_w;
    logic signed [65:0] mac_sum, psum;

    assign in_op   = s_axis_tdata[2:0];
    assign in_slot = s_axis_tdata[7:3];
    assign in_x    = s_axis_tdata[39:8];
    assign in_y    = s_axis_tdata[71:40];
    assign in_z    = s_axis_tdata[103:72];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    assign chain_empty = (r_n == '0) || (r_len == '0);
    assign emit_last   = r_empty || (r_idx == r_n);

    assign map_i    = MW'(r_idx - LW'(1));
    assign rd_slot  = (r_state == ST_RDP) ? r_pitch[map_i] : r_yaw[map_i];
    assign rd_ok    = !rd_slot[6] && (int'(rd_slot) < int'(r_jvc)) && r_av[AW'(rd_slot[5:0])];
    assign cord_ang = r_ang_ok ? r_mem_q : '0;

    // operand selection for the shared multiplier
    always_comb begin
        case (r_job)
            4'd0, 4'd1, 4'd6, 4'd7, 4'd12: row = 2'd0;
            4'd2, 4'd3, 4'd8, 4'd9, 4'd13: row = 2'd1;
            default:                       row = 2'd2;
        endcase
        if (r_job < JOB_R0) begin
            ridx = 4'(3 * row) + (r_ph[0] ? 4'd2 : 4'd0);
        end else if (r_job < JOB_P0) begin
            ridx = 4'(3 * row) + 4'd1;
        end else begin
            ridx = 4'(3 * row);
        end
        rval = r_rw[ridx];
        if (r_job < JOB_R0) begin
            mul_a = rval;
            if (!r_job[0]) begin
                mul_b = r_ph[0] ? -r_sp : r_cp;
            end else begin
                mul_b = r_ph[0] ? r_cp : r_sp;
            end
        end else if (r_job < JOB_P0) begin
            mul_a = r_ph[0] ? rval : r_t0[row];
            if (!r_job[0]) begin
                mul_b = r_ph[0] ? r_sy : r_cy;
            end else begin
                mul_b = r_ph[0] ? r_cy : -r_sy;
            end
        end else begin
            mul_a = r_ph[0] ? '0 : $signed({1'b0, r_len});
            mul_b = r_ph[0] ? '0 : rval;
        end
        mac_sum = 66'(r_acc) + 66'(r_prod);
        res_w   = sat32(mac_sum >>> 30);
        psum    = r_sub ? (66'(r_p[row]) - 66'(r_res)) : (66'(r_p[row]) + 66'(r_res));
    end

    scfk_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_angle (cord_ang),
        .o_done  (cord_done),
        .o_sin   (cord_sin),
        .o_cos   (cord_cos)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && in_op == OP_COMPUTE) begin
                    n_state = chain_empty ? ST_EMIT : ST_MAC;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    if (emit_last) begin
                        n_state = ST_IDLE;
                    end else if (r_idx == '0) begin
                        n_state = ST_TAIL;
                    end else begin
                        n_state = ST_RDP;
                    end
                end
            end
            ST_TAIL: n_state = ST_EMIT;
            ST_RDP:  n_state = ST_CP;
            ST_CP:   n_state = ST_WCP;
            ST_WCP:  if (cord_done) n_state = ST_RDY;
            ST_RDY:  n_state = ST_CY;
            ST_CY:   n_state = ST_WCY;
            ST_WCY:  if (cord_done) n_state = ST_MAC;
            ST_MAC:  if (r_ph == 2'd3 && r_job == JOB_LAST) n_state = ST_EMIT;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        out_load      = (r_state == ST_EMIT) && (!r_ov || m_axis_tready);
        rd_en         = (r_state == ST_RDP) || (r_state == ST_RDY);
        cord_start    = (r_state == ST_CP) || (r_state == ST_CY);
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {3'b0, r_out_p[2], r_out_p[1], r_out_p[0], r_out_idx};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_empty;

    // control state, configuration and stored chain description
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_len   <= '0;
            r_n     <= '0;
            r_jvc   <= '0;
            r_av    <= '0;
            r_idx   <= '0;
            r_job   <= '0;
            r_ph    <= '0;
            r_sub   <= 1'b0;
            r_empty <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_rot_ld[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_tail[i] <= '0;
            end
            for (int i = 0; i < NMAP; i++) begin
                r_pitch[i] <= 7'h7F;
                r_yaw[i]   <= 7'h7F;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LENGTH: r_len <= i_cfg_data;
                    CFG_COUNT:  r_n <= (int'(i_cfg_data[4:0]) > MAX_LINKS) ?
                                       LW'(MAX_LINKS) : LW'(i_cfg_data[4:0]);
                    CFG_JVC:    r_jvc <= (int'(i_cfg_data[5:0]) > MAX_JOINT_VALUES) ?
                                         JW'(MAX_JOINT_VALUES) : JW'(i_cfg_data[5:0]);
                    default: ;
                endcase
            end
            if (in_acc) begin
                case (in_op)
                    OP_ROT: begin
                        for (int c = 0; c < 3; c++) begin
                            if (int'(in_slot) == c) begin
                                r_rot_ld[c]     <= in_x;
                                r_rot_ld[3 + c] <= in_y;
                                r_rot_ld[6 + c] <= in_z;
                            end
                        end
                    end
                    OP_TAIL: begin
                        r_tail[0] <= in_x;
                        r_tail[1] <= in_y;
                        r_tail[2] <= in_z;
                    end
                    OP_ANGLE: begin
                        if (int'(in_slot) < MAX_JOINT_VALUES) begin
                            r_av[AW'(in_slot)] <= 1'b1;
                        end
                    end
                    OP_MAP: begin
                        if (int'(in_slot) < NMAP) begin
                            r_pitch[MW'(in_slot)] <= map_value(in_x);
                            r_yaw[MW'(in_slot)]   <= map_value(in_y);
                        end
                    end
                    OP_COMPUTE: begin
                        r_idx   <= '0;
                        r_empty <= chain_empty;
                        r_job   <= JOB_P0;
                        r_ph    <= '0;
                        r_sub   <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (r_state == ST_TAIL) begin
                r_idx <= LW'(1);
            end
            if (r_state == ST_WCY && cord_done) begin
                r_job <= '0;
                r_ph  <= '0;
                r_sub <= 1'b0;
            end
            if (r_state == ST_MAC) begin
                r_ph <= r_ph + 2'd1;
                if (r_ph == 2'd3) begin
                    r_job <= r_job + 4'd1;
                    if (r_job == JOB_LAST) begin
                        r_idx <= r_sub ? '0 : r_idx + LW'(1);
                    end
                end
            end
        end
    end

    // joint angle memory
    always_ff @(posedge i_clk) begin
        if (in_acc && in_op == OP_ANGLE && int'(in_slot) < MAX_JOINT_VALUES) begin
            r_mem[AW'(in_slot)] <= in_x;
        end
        if (rd_en) begin
            r_mem_q  <= r_mem[AW'(rd_slot[5:0])];
            r_ang_ok <= rd_ok;
        end
    end

    // working matrix, positions and multiply-accumulate
    always_ff @(posedge i_clk) begin
        if (in_acc && in_op == OP_COMPUTE) begin
            for (int i = 0; i < 9; i++) begin
                r_rw[i] <= r_rot_ld[i];
            end
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= chain_empty ? '0 : r_tail[i];
            end
        end
        if (r_state == ST_TAIL) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= r_tail[i];
            end
        end
        if (r_state == ST_WCP && cord_done) begin
            r_sp <= cord_sin;
            r_cp <= cord_cos;
        end
        if (r_state == ST_WCY && cord_done) begin
            r_sy <= cord_sin;
            r_cy <= cord_cos;
        end
        if (r_state == ST_MAC) begin
            case (r_ph)
                2'd0: r_prod <= mul_a * mul_b;
                2'd1: begin
                    r_acc  <= 65'(r_prod) + 65'sd536870912;
                    r_prod <= mul_a * mul_b;
                end
                2'd2: r_res <= res_w;
                default: begin
                    if (r_job < JOB_R0) begin
                        if (!r_job[0]) begin
                            r_t0[row] <= r_res;
                        end else begin
                            r_t2[row] <= r_res;
                        end
                    end else if (r_job < JOB_P0) begin
                        if (!r_job[0]) begin
                            r_rw[4'(3 * row)] <= r_res;
                        end else begin
                            r_rw[4'(3 * row) + 4'd1] <= r_res;
                            r_rw[4'(3 * row) + 4'd2] <= r_t2[row];
                        end
                    end else begin
                        r_p[row] <= sat32(psum);
                    end
                end
            endcase
        end
        if (out_load) begin
            r_out_idx   <= 5'(r_idx);
            r_out_last  <= emit_last;
            r_out_empty <= r_empty;
            for (int i = 0; i < 3; i++) begin
                r_out_p[i] <= r_p[i];
            end
        end
    end

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out_empty) |-> r_out_last)
        else $error("empty result without last");

    a_cordic_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_done |-> (r_state == ST_WCP || r_state == ST_WCY))
        else $error("cordic result outside a wait step");

    a_busy_after_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_op == OP_COMPUTE) |=> !s_axis_tready)
        else $error("input taken right after a compute item");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && !r_empty) |-> (r_idx <= r_n))
        else $error("endpoint index beyond link count");

endmodule

/* hdl/scfk_cordic.sv */
module scfk_cordic import scfk_pkg::*; #(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic signed [31:0] i_angle,
    output logic         o_done,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    localparam int       MAGW      = 46;
    localparam logic [5:0] LAST_STEP = 6'(CORDIC_STEPS - 1);

    t_cstate r_state, n_state;

    logic [MAGW-1:0] r_mag;
    logic            r_neg;
    logic [3:0]      r_j;
    logic [5:0]      r_i;
    t_cw             r_x, r_y, r_z;
    logic            r_flip;

    logic [31:0]     ang_abs;
    logic [MAGW-1:0] step_sub;
    t_cw             z_raw, z_wrap, dx, dy, at, x_cl, y_cl, x_out, y_out;

    always_comb begin
        ang_abs  = i_angle[31] ? 32'(-i_angle) : i_angle;
        step_sub = MAGW'(TWO_PI_Q30) << r_j;
        z_raw    = $signed(r_mag[ZW-1:0]);
        if (r_neg) begin
            z_raw = -z_raw;
        end
        z_wrap = z_raw;
        if (z_raw > PI_Q30) begin
            z_wrap = z_raw - TWO_PI_Q30;
        end else if (z_raw <= -PI_Q30) begin
            z_wrap = z_raw + TWO_PI_Q30;
        end
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        at = $signed({5'b0, atan_q30(r_i[4:0])});
        x_cl = (r_x > ONE_Q30) ? ONE_Q30 : ((r_x < -ONE_Q30) ? -ONE_Q30 : r_x);
        y_cl = (r_y > ONE_Q30) ? ONE_Q30 : ((r_y < -ONE_Q30) ? -ONE_Q30 : r_y);
        x_out = r_flip ? -x_cl : x_cl;
        y_out = r_flip ? -y_cl : y_cl;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE: if (i_start) n_state = CS_RED;
            CS_RED:  if (r_j == 4'd0) n_state = CS_WRAP;
            CS_WRAP: n_state = CS_FOLD;
            CS_FOLD: n_state = CS_ITER;
            CS_ITER: if (r_i == LAST_STEP) n_state = CS_FIN;
            CS_FIN:  n_state = CS_IDLE;
            default: n_state = CS_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == CS_FIN);
        o_sin  = y_out[31:0];
        o_cos  = x_out[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            CS_IDLE: begin
                r_mag <= {ang_abs, 14'b0};
                r_neg <= i_angle[31];
                r_j   <= 4'd12;
            end
            CS_RED: begin
                if (r_mag >= step_sub) begin
                    r_mag <= r_mag - step_sub;
                end
                r_j <= r_j - 4'd1;
            end
            CS_WRAP: r_z <= z_wrap;
            CS_FOLD: begin
                if (r_z > HALF_PI_Q30) begin
                    r_z    <= r_z - PI_Q30;
                    r_flip <= 1'b1;
                end else if (r_z < -HALF_PI_Q30) begin
                    r_z    <= r_z + PI_Q30;
                    r_flip <= 1'b1;
                end else begin
                    r_flip <= 1'b0;
                end
                r_x <= CORDIC_GAIN;
                r_y <= '0;
                r_i <= '0;
            end
            CS_ITER: begin
                if (r_z >= 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end
                r_i <= r_i + 6'd1;
            end
            default: ;
        endcase
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb import scfk_pkg::*;;

    localparam int NLINK = 16;
    localparam int NJV = 32;
    localparam int NSTEP = 24;
    localparam longint PI_C = 64'sd3373259426;
    localparam longint TWO_PI_C = 64'sd6746518852;
    localparam longint HALF_PI_C = 64'sd1686629713;
    localparam longint GAIN_C = 64'sd652032874;
    localparam longint ONE_C = 64'sd1073741824;
    localparam longint CYCLE_LIMIT = 2000000;

    localparam longint ATAN_T [0:NSTEP-1] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    typedef struct {
        logic [4:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               empty;
        logic               last;
    } t_point;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic [0:0]   m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_index = '0;
    logic [30:0]  i_cfg_data = '0;

    serial_chain_forward_kinematics_core uut (.*);

    // model state
    longint link_len, link_cnt, jv_cnt;
    longint rot_m [9];
    longint tail_p [3];
    longint angles [NJV];
    longint pitch_map [NLINK-1];
    longint yaw_map [NLINK-1];

    t_point expected_points [$];
    int     errors = 0;
    int     items_sent = 0;
    bit     quiet = 1'b0;
    int     stall_left = 0;
    longint cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mul_round(longint a, longint b);
        return sat32((a * b + (64'sd1 << 29)) >>> 30);
    endfunction

    function automatic longint dot2(longint a, longint b, longint c, longint d);
        return sat32((a * b + c * d + (64'sd1 << 29)) >>> 30);
    endfunction

    function automatic void trig(longint ang, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit flip;
        z = (ang * 16384) % TWO_PI_C;
        x = GAIN_C;
        y = 0;
        flip = 1'b0;
        if (z > PI_C) z -= TWO_PI_C;
        if (z <= -PI_C) z += TWO_PI_C;
        if (z > HALF_PI_C) begin
            z -= PI_C;
            flip = 1'b1;
        end else if (z < -HALF_PI_C) begin
            z += PI_C;
            flip = 1'b1;
        end
        for (int i = 0; i < NSTEP; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_T[i];
            end else begin
                x += dx; y -= dy; z += ATAN_T[i];
            end
        end
        if (x > ONE_C) x = ONE_C;
        if (x < -ONE_C) x = -ONE_C;
        if (y > ONE_C) y = ONE_C;
        if (y < -ONE_C) y = -ONE_C;
        if (flip) begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint angle_of(longint sl);
        if (sl < 0 || sl >= jv_cnt) return 0;
        return angles[sl];
    endfunction

    function automatic longint to_map(longint v);
        return (v < 0 || v > 63) ? -1 : v;
    endfunction

    function automatic void push_point(int k, longint p [3], bit lst, bit emp);
        t_point e;
        e.idx = k[4:0];
        e.x = p[0][31:0];
        e.y = p[1][31:0];
        e.z = p[2][31:0];
        e.empty = emp;
        e.last = lst;
        expected_points.insert(expected_points.size(), e);
    endfunction

    function automatic void predict_chain(logic [2:0] op, logic [4:0] sl,
            longint vx, longint vy, longint vz);
        longint r [9];
        longint t [9];
        longint p [3];
        longint sp, cp, sy, cy;
        if (op == OP_ROT) begin
            if (sl < 3) begin
                rot_m[sl] = vx; rot_m[3+sl] = vy; rot_m[6+sl] = vz;
            end
        end else if (op == OP_TAIL) begin
            tail_p[0] = vx; tail_p[1] = vy; tail_p[2] = vz;
        end else if (op == OP_ANGLE) begin
            if (sl < NJV) angles[sl] = vx;
        end else if (op == OP_MAP) begin
            if (sl < NLINK - 1) begin
                pitch_map[sl] = to_map(vx);
                yaw_map[sl] = to_map(vy);
            end
        end else if (op == OP_COMPUTE) begin
            if (link_cnt == 0 || link_len == 0) begin
                p = '{0, 0, 0};
                push_point(0, p, 1'b1, 1'b1);
            end else begin
                r = rot_m;
                for (int i = 0; i < 3; i++)
                    p[i] = sat32(tail_p[i] - mul_round(link_len, r[3*i]));
                push_point(0, p, 1'b0, 1'b0);
                p = tail_p;
                push_point(1, p, link_cnt == 1, 1'b0);
                for (int k = 1; k < link_cnt; k++) begin
                    trig(angle_of(pitch_map[k-1]), sp, cp);
                    trig(angle_of(yaw_map[k-1]), sy, cy);
                    for (int i = 0; i < 3; i++) begin
                        t[3*i] = dot2(r[3*i], cp, r[3*i+2], -sp);
                        t[3*i+1] = r[3*i+1];
                        t[3*i+2] = dot2(r[3*i], sp, r[3*i+2], cp);
                    end
                    for (int i = 0; i < 3; i++) begin
                        r[3*i] = dot2(t[3*i], cy, t[3*i+1], sy);
                        r[3*i+1] = dot2(t[3*i], -sy, t[3*i+1], cy);
                        r[3*i+2] = t[3*i+2];
                    end
                    for (int i = 0; i < 3; i++)
                        p[i] = sat32(p[i] + mul_round(link_len, r[3*i]));
                    push_point(k + 1, p, k + 1 == link_cnt, 1'b0);
                end
            end
        end
    endfunction

    task automatic send_item(logic [2:0] op, logic [4:0] sl, logic [31:0] vx,
            logic [31:0] vy, logic [31:0] vz);
        int gap;
        if (!quiet && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {vz, vy, vx, sl, op};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_chain(op, sl, longint'(signed'(vx)), longint'(signed'(vy)),
                      longint'(signed'(vz)));
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg idx, logic [30:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_LENGTH) link_len = val;
        else if (idx == CFG_COUNT) link_cnt = (val[4:0] > NLINK) ? NLINK : val[4:0];
        else if (idx == CFG_JVC) jv_cnt = (val[5:0] > NJV) ? NJV : val[5:0];
    endtask

    task automatic set_chain(logic [30:0] len, logic [30:0] cnt, logic [30:0] jvc);
        wait_idle();
        write_reg(CFG_LENGTH, len);
        write_reg(CFG_COUNT, cnt);
        write_reg(CFG_JVC, jvc);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_empty_chain();
        send_item(OP_COMPUTE, 5'd0, 32'h0, 32'h0, 32'h0);
        set_chain(31'd65536, 31'd0, 31'd4);
        send_item(OP_COMPUTE, 5'd7, 32'hFFFF_FFFF, 32'h0, 32'h1);
    endtask

    task automatic test_directed();
        send_item(OP_ROT, 5'd0, 32'h4000_0000, 32'h0, 32'h0);
        send_item(OP_ROT, 5'd1, 32'h0, 32'h4000_0000, 32'h0);
        send_item(OP_ROT, 5'd2, 32'h0, 32'h0, 32'h4000_0000);
        send_item(OP_ROT, 5'd3, 32'h1234_5678, 32'h1, 32'h2);
        send_item(OP_TAIL, 5'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
        send_item(OP_ANGLE, 5'd0, 32'd102944, 32'h0, 32'h0);
        send_item(OP_ANGLE, 5'd1, -32'sd205887, 32'h0, 32'h0);
        send_item(OP_ANGLE, 5'd31, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_item(OP_ANGLE, 5'd2, 32'h8000_0000, 32'h0, 32'h0);
        send_item(OP_MAP, 5'd0, 32'd0, 32'd1, 32'h0);
        send_item(OP_MAP, 5'd1, 32'd31, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_MAP, 5'd14, 32'd64, 32'd2, 32'h0);
        send_item(OP_MAP, 5'd15, 32'd1, 32'd1, 32'h0);
        send_item(3'd5, 5'd0, 32'h0, 32'h0, 32'h0);
        send_item(3'd7, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_chain(31'd65536, 31'd16, 31'd32);
        send_item(OP_COMPUTE, 5'd0, 32'h0, 32'h0, 32'h0);
        set_chain(31'h7FFF_FFFF, 31'd1, 31'd63);
        send_item(OP_COMPUTE, 5'd0, 32'h0, 32'h0, 32'h0);
        send_item(OP_ROT, 5'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_TAIL, 5'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        set_chain(31'h7FFF_FFFF, 31'd31, 31'd2);
        send_item(OP_COMPUTE, 5'd0, 32'h0, 32'h0, 32'h0);
    endtask

    task automatic random_config();
        logic [30:0] len, cnt;
        case ($urandom_range(0, 5))
            0: len = 31'd0;
            1: len = 31'h7FFF_FFFF;
            2: len = 31'($urandom);
            default: len = 31'($urandom_range(1, 8) << 16);
        endcase
        case ($urandom_range(0, 7))
            0: cnt = 31'd0;
            1: cnt = 31'd16;
            2: cnt = 31'($urandom_range(17, 31));
            default: cnt = 31'($urandom_range(1, 4));
        endcase
        set_chain(len, cnt, 31'($urandom_range(0, 63)));
    endtask

    task automatic random_load();
        logic [4:0] sl;
        case ($urandom_range(0, 9))
            0, 1: send_item(OP_ROT, 5'($urandom_range(0, 2)), $urandom, $urandom, $urandom);
            2: send_item(OP_TAIL, 5'($urandom), $urandom, $urandom, $urandom);
            3, 4: begin
                sl = 5'($urandom);
                if ($urandom_range(0, 1))
                    send_item(OP_ANGLE, sl, $urandom, $urandom, $urandom);
                else
                    send_item(OP_ANGLE, sl, $urandom_range(0, 411774) - 205887,
                              $urandom, $urandom);
            end
            5, 6: send_item(OP_MAP, 5'($urandom_range(0, 14)), $urandom_range(0, 70) - 2,
                            $urandom_range(0, 70) - 2, $urandom);
            7: send_item(OP_MAP, 5'($urandom), $urandom, $urandom, $urandom);
            8: send_item(3'($urandom_range(5, 7)), 5'($urandom), $urandom, $urandom,
                         $urandom);
            default: send_item(OP_ROT, 5'($urandom), $urandom, $urandom, $urandom);
        endcase
    endtask

    task automatic test_random();
        int n;
        while (items_sent < 225) begin
            if (items_sent > 190) quiet = 1'b1;
            if ($urandom_range(0, 2) == 0) random_config();
            n = $urandom_range(2, 10);
            repeat (n) random_load();
            send_item(OP_COMPUTE, 5'($urandom), $urandom, $urandom, $urandom);
        end
    endtask

    always @(posedge i_clk) begin
        t_point e;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_points.size() == 0) begin
                $error("unexpected item idx=%0d", m_axis_tdata[4:0]);
                errors++;
            end else begin
                e = expected_points.pop_front();
                if (m_axis_tdata[4:0] !== e.idx) begin
                    $error("point_index exp %0d got %0d", e.idx, m_axis_tdata[4:0]);
                    errors++;
                end
                if (m_axis_tdata[36:5] !== e.x) begin
                    $error("point_x exp %0d got %0d", e.x, $signed(m_axis_tdata[36:5]));
                    errors++;
                end
                if (m_axis_tdata[68:37] !== e.y) begin
                    $error("point_y exp %0d got %0d", e.y, $signed(m_axis_tdata[68:37]));
                    errors++;
                end
                if (m_axis_tdata[100:69] !== e.z) begin
                    $error("point_z exp %0d got %0d", e.z, $signed(m_axis_tdata[100:69]));
                    errors++;
                end
                if (m_axis_tuser[0] !== e.empty) begin
                    $error("empty_res exp %0d got %0d", e.empty, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last exp %0d got %0d", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        link_len = 0; link_cnt = 0; jv_cnt = 0;
        foreach (rot_m[i]) rot_m[i] = 0;
        foreach (tail_p[i]) tail_p[i] = 0;
        foreach (angles[i]) angles[i] = 0;
        foreach (pitch_map[i]) begin
            pitch_map[i] = -1; yaw_map[i] = -1;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_chain();
        test_directed();
        test_random();
        wait_idle();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_points.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
